@@ sv/tbge_pkg.sv @@
// Shared types, constants and tables for the ten-band graphic equalizer.
package tbge_pkg;

  localparam int unsigned Bands     = 10;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned CoefW     = 32;
  localparam int unsigned GainRegW  = 30;
  localparam int unsigned PreampW   = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned BandIdxW  = 4;

  localparam logic [CfgIdxW-1:0] CfgGainsLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGainsHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPreamp    = 2'd2;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdClear  = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [SampleW-1:0] sample;
    logic [7:0]               chan;
  } item_t;

  // Round a value given in millionths to Q2.29
  function automatic logic signed [CoefW-1:0] q29(input longint m);
    longint r;
    r = (m * 64'sd536870912 + ((m < 0) ? -64'sd500000 : 64'sd500000)) / 64'sd1000000;
    q29 = CoefW'(r);
  endfunction

  // Round a value given in billionths to Q4.27
  function automatic logic signed [SampleW-1:0] q27(input longint n);
    longint r;
    r = (n * 64'sd134217728 + 64'sd500000000) / 64'sd1000000000;
    q27 = SampleW'(r);
  endfunction

  // Q2.29 band constants: alpha base, beta (y[n-2]), gamma (y[n-1])
  function automatic logic signed [CoefW-1:0] band_base(input logic [BandIdxW-1:0] k);
    case (k)
      4'd0: band_base = q29(64'sd3013);
      4'd1: band_base = q29(64'sd8490);
      4'd2: band_base = q29(64'sd15374);
      4'd3: band_base = q29(64'sd29328);
      4'd4: band_base = q29(64'sd47918);
      4'd5: band_base = q29(64'sd130408);
      4'd6: band_base = q29(64'sd226555);
      4'd7: band_base = q29(64'sd344937);
      4'd8: band_base = q29(64'sd366438);
      4'd9: band_base = q29(64'sd379009);
      default: band_base = '0;
    endcase
  endfunction

  function automatic logic signed [CoefW-1:0] band_beta(input logic [BandIdxW-1:0] k);
    case (k)
      4'd0: band_beta = q29(-64'sd993973);
      4'd1: band_beta = q29(-64'sd983019);
      4'd2: band_beta = q29(-64'sd969252);
      4'd3: band_beta = q29(-64'sd941343);
      4'd4: band_beta = q29(-64'sd904163);
      4'd5: band_beta = q29(-64'sd739184);
      4'd6: band_beta = q29(-64'sd546889);
      4'd7: band_beta = q29(-64'sd310127);
      4'd8: band_beta = q29(-64'sd267123);
      4'd9: band_beta = q29(-64'sd241981);
      default: band_beta = '0;
    endcase
  endfunction

  function automatic logic signed [CoefW-1:0] band_gamma(input logic [BandIdxW-1:0] k);
    case (k)
      4'd0: band_gamma = q29(64'sd1993901);
      4'd1: band_gamma = q29(64'sd1982437);
      4'd2: band_gamma = q29(64'sd1967331);
      4'd3: band_gamma = q29(64'sd1934254);
      4'd4: band_gamma = q29(64'sd1884869);
      4'd5: band_gamma = q29(64'sd1582718);
      4'd6: band_gamma = q29(64'sd1015267);
      4'd7: band_gamma = q29(-64'sd181410);
      4'd8: band_gamma = q29(-64'sd521151);
      4'd9: band_gamma = q29(-64'sd808451);
      default: band_gamma = '0;
    endcase
  endfunction

  // Q4.27 linear gain for a six-bit dB code, clamped to +-18
  function automatic logic signed [SampleW-1:0] db_gain(input logic [5:0] code);
    logic signed [5:0] g;
    logic [5:0]        idx;
    g = signed'(code);
    if (g < -6'sd18) g = -6'sd18;
    if (g > 6'sd18) g = 6'sd18;
    idx = 6'(g + 6'sd18);
    case (idx)
      6'd0:  db_gain = q27(64'sd125892541);
      6'd1:  db_gain = q27(64'sd141253754);
      6'd2:  db_gain = q27(64'sd158489319);
      6'd3:  db_gain = q27(64'sd177827941);
      6'd4:  db_gain = q27(64'sd199526231);
      6'd5:  db_gain = q27(64'sd223872114);
      6'd6:  db_gain = q27(64'sd251188643);
      6'd7:  db_gain = q27(64'sd281838293);
      6'd8:  db_gain = q27(64'sd316227766);
      6'd9:  db_gain = q27(64'sd354813389);
      6'd10: db_gain = q27(64'sd398107171);
      6'd11: db_gain = q27(64'sd446683592);
      6'd12: db_gain = q27(64'sd501187234);
      6'd13: db_gain = q27(64'sd562341325);
      6'd14: db_gain = q27(64'sd630957344);
      6'd15: db_gain = q27(64'sd707945784);
      6'd16: db_gain = q27(64'sd794328235);
      6'd17: db_gain = q27(64'sd891250938);
      6'd18: db_gain = q27(64'sd1000000000);
      6'd19: db_gain = q27(64'sd1122018454);
      6'd20: db_gain = q27(64'sd1258925412);
      6'd21: db_gain = q27(64'sd1412537545);
      6'd22: db_gain = q27(64'sd1584893192);
      6'd23: db_gain = q27(64'sd1778279410);
      6'd24: db_gain = q27(64'sd1995262315);
      6'd25: db_gain = q27(64'sd2238721139);
      6'd26: db_gain = q27(64'sd2511886432);
      6'd27: db_gain = q27(64'sd2818382931);
      6'd28: db_gain = q27(64'sd3162277660);
      6'd29: db_gain = q27(64'sd3548133892);
      6'd30: db_gain = q27(64'sd3981071706);
      6'd31: db_gain = q27(64'sd4466835922);
      6'd32: db_gain = q27(64'sd5011872336);
      6'd33: db_gain = q27(64'sd5623413252);
      6'd34: db_gain = q27(64'sd6309573445);
      6'd35: db_gain = q27(64'sd7079457844);
      6'd36: db_gain = q27(64'sd7943282347);
      default: db_gain = q27(64'sd1000000000);
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh7FFFFFFF) sat32 = 32'sh7FFFFFFF;
    else if (v < -48'sh80000000) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ sv/tbge_front.sv @@
// Front end: accept words, drop out-of-range channels, queue work for the back end.
module tbge_front #(
  parameter int unsigned ChanW = 1,
  parameter int unsigned ChannelCount = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [39:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  q_pop_i,
  output logic                  q_valid_o,
  output tbge_pkg::item_t       q_item_o
);
  import tbge_pkg::*;

  localparam int unsigned Depth = 4;

  item_t      mem_q [Depth];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       push, keep;
  logic [ChanW-1:0] ch;
  item_t      it;

  assign s_axis_tready = (cnt_q != 3'(Depth));
  assign ch   = s_axis_tdata[32 +: ChanW];
  assign keep = (s_axis_tuser == CmdClear) || (32'(ch) < ChannelCount);
  assign push = s_axis_tvalid && s_axis_tready && keep;
  assign q_valid_o = (cnt_q != 3'd0);
  assign q_item_o  = mem_q[rd_q];

  always_comb begin
    it.cmd    = s_axis_tuser;
    it.sample = signed'(s_axis_tdata[31:0]);
    it.chan   = 8'(ch);
    wr_d  = push ? wr_q + 2'd1 : wr_q;
    rd_d  = q_pop_i ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + 3'(push) - 3'(q_pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= it;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      wr_q <= wr_d; rd_q <= rd_d; cnt_q <= cnt_d;
    end
  end
endmodule

@@ sv/tbge_back.sv @@
// Back end: per-band sequencer over a shared multiplier with history memory.
module tbge_back #(
  parameter int unsigned ChanW = 1,
  parameter int unsigned ChannelCount = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [29:0]           gains_low_i,
  input  logic [29:0]           gains_high_i,
  input  logic [5:0]            preamp_i,
  input  logic                  q_valid_i,
  input  tbge_pkg::item_t       q_item_i,
  output logic                  q_pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata
);
  import tbge_pkg::*;

  localparam int unsigned Hist  = ChannelCount * Bands;
  localparam int unsigned HistW = $clog2(Hist);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLR   = 7'b0000010,
    S_ALPHA = 7'b0000100,
    S_PRE   = 7'b0001000,
    S_BAND  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  item_t  it_q;
  logic [BandIdxW-1:0] k_q;
  logic [2:0]          ph_q;
  logic signed [63:0]  p_q;
  logic signed [SampleW-1:0] alpha_q [Bands];
  logic signed [SampleW-1:0] diff_q, x1_q, x2_q, y1_q, y2_q;
  logic signed [47:0]  acc_q, t_q;
  logic signed [SampleW-1:0] y1m [Hist];
  logic signed [SampleW-1:0] y2m [Hist];
  logic signed [SampleW-1:0] xh [ChannelCount][3];
  logic [HistW-1:0]    clr_q;
  logic [HistW-1:0]    ba;
  logic signed [SampleW-1:0] out_q;
  logic [ChanW-1:0]   och_q;
  logic               ovalid_q;
  logic [5:0]         gcode;
  logic signed [SampleW-1:0] gm1;
  logic signed [SampleW-1:0] pre27;
  logic signed [SampleW-1:0] ma, mb;
  logic               skip;
  logic [ChanW-1:0]   ch;

  assign ch    = it_q.chan[ChanW-1:0];
  assign ba    = HistW'(32'(ch) * Bands + 32'(k_q));
  assign pre27 = db_gain(preamp_i);
  assign gcode = (k_q < 4'd5) ? gains_low_i[6*k_q +: 6] : gains_high_i[6*(k_q-4'd5) +: 6];
  assign gm1   = db_gain(gcode) - 32'sd134217728;
  assign skip  = !k_q[0] && (alpha_q[k_q] == 0) && (alpha_q[k_q+4'd1] == 0);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'd0, och_q, out_q};

  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      S_ALPHA: begin
        if (ph_q == 3'd0) begin ma = band_base(k_q); mb = gm1; end
        else begin ma = SampleW'(p_q >>> 29); mb = pre27; end
      end
      S_PRE: begin ma = pre27 >>> 2; mb = xh[ch][0]; end
      S_BAND: begin
        case (ph_q)
          3'd1: begin ma = alpha_q[k_q]; mb = diff_q; end
          3'd2: begin ma = band_gamma(k_q); mb = y1_q; end
          default: begin ma = band_beta(k_q); mb = y2_q; end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_valid_i) state_d = q_item_i.cmd ? S_CLR : S_ALPHA;
      S_CLR:   if (32'(clr_q) == Hist - 1) state_d = S_IDLE;
      S_ALPHA: if (k_q == 4'(Bands-1) && ph_q == 3'd2) state_d = S_PRE;
      S_PRE:   if (ph_q == 3'd1) state_d = S_BAND;
      S_BAND:  if ((skip && ph_q == 3'd0 && k_q == 4'(Bands-2)) ||
                   (ph_q == 3'd4 && k_q == 4'(Bands-1))) state_d = S_DONE;
      S_DONE:  state_d = S_OUT;
      S_OUT:   if (!ovalid_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= 64'(ma) * 64'(mb);
    if (state_q == S_IDLE && q_valid_i) it_q <= q_item_i;
    case (state_q)
      S_CLR: begin
        y1m[clr_q] <= '0;
        y2m[clr_q] <= '0;
        for (int c = 0; c < ChannelCount; c++)
          for (int j = 0; j < 3; j++) xh[c][j] <= '0;
      end
      S_ALPHA: begin
        if (ph_q == 3'd2) alpha_q[k_q] <= 32'(p_q >>> 29);
      end
      S_PRE: begin
        if (ph_q == 3'd0) begin
          x1_q <= xh[ch][0]; x2_q <= xh[ch][1];
          diff_q <= 32'((33'(xh[ch][0]) - 33'(xh[ch][2])) >>> 1);
        end else begin
          acc_q <= 48'(p_q >>> 25);
        end
      end
      S_BAND: begin
        case (ph_q)
          3'd0: begin y1_q <= y1m[ba]; y2_q <= y2m[ba]; end
          3'd2: t_q <= 48'(p_q >>> 25);
          3'd3: t_q <= t_q + 48'(p_q >>> 29);
          3'd4: begin
            y1m[ba] <= sat32(t_q + 48'(p_q >>> 29));
            y2m[ba] <= y1_q;
            acc_q <= acc_q + 48'(sat32(t_q + 48'(p_q >>> 29)));
          end
          default: ;
        endcase
      end
      S_DONE: begin
        xh[ch][2] <= x2_q; xh[ch][1] <= x1_q; xh[ch][0] <= it_q.sample;
      end
      S_OUT: if (!ovalid_q || m_axis_tready) begin
        out_q <= sat32(acc_q); och_q <= ch;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; k_q <= '0; ph_q <= '0; clr_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin k_q <= '0; ph_q <= '0; clr_q <= '0; end
        S_CLR: clr_q <= clr_q + 1'b1;
        S_ALPHA: begin
          if (ph_q == 3'd2) begin
            ph_q <= '0;
            k_q <= (k_q == 4'(Bands-1)) ? '0 : k_q + 4'd1;
          end else ph_q <= ph_q + 3'd1;
        end
        S_PRE: ph_q <= (ph_q == 3'd1) ? 3'd0 : ph_q + 3'd1;
        S_BAND: begin
          if (skip && ph_q == 3'd0) k_q <= k_q + 4'd2;
          else if (ph_q == 3'd4) begin ph_q <= '0; k_q <= k_q + 4'd1; end
          else ph_q <= ph_q + 3'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ sv/ten_band_graphic_equalizer_core.sv @@
// Ten-band graphic equalizer top level: config registers, front end, queue and band engine.
// Each sample runs through one shared 32x32 multiplier that computes the ten band gains,
// then the preamp term, then three products per active band; a held band pair is passed
// over. Separate states take the word, update the input history and load the output
// register. A clear command sweeps the history one entry per cycle, and the same sweep
// runs once after reset before the first word leaves the queue. Words queue up to four
// deep while the engine is busy.
module ten_band_graphic_equalizer_core #(
  parameter int unsigned CHANNEL_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // sample_in, channel_in
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // sample_out, channel_out
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [29:0] cfg_data_i
);
  import tbge_pkg::*;

  localparam int unsigned ChanW = 1;

  logic [29:0] gl_q, gh_q;
  logic [5:0]  pre_q;
  logic        qv, pop;
  item_t       qi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gl_q <= '0; gh_q <= '0; pre_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgGainsLow:  gl_q <= cfg_data_i;
        CfgGainsHigh: gh_q <= cfg_data_i;
        CfgPreamp:    pre_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  tbge_front #(.ChanW(ChanW), .ChannelCount(CHANNEL_COUNT)) u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .q_pop_i(pop), .q_valid_o(qv), .q_item_o(qi)
  );

  tbge_back #(.ChanW(ChanW), .ChannelCount(CHANNEL_COUNT)) u_back (
    .clk_i, .rst_ni, .gains_low_i(gl_q), .gains_high_i(gh_q), .preamp_i(pre_q),
    .q_valid_i(qv), .q_item_i(qi), .q_pop_o(pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule

@@ tb/tb_ten_band_graphic_equalizer_core.sv @@
// Testbench for the ten-band graphic equalizer core: directed and random stream traffic checked by a scoreboard.
`timescale 1ns / 1ps

module tb_ten_band_graphic_equalizer_core;
  import tbge_pkg::*;

  localparam int unsigned ChanCount  = 2;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleWait = 300;

  class eq_scoreboard;
    longint base_q29 [Bands];
    longint beta_q29 [Bands];
    longint gamma_q29[Bands];
    longint gain_q27 [37];
    logic [29:0] gains_lo;
    logic [29:0] gains_hi;
    logic [5:0]  preamp;
    longint x_hist[ChanCount][3];
    longint y_hist[ChanCount][2*Bands];
    logic [32:0] pending[$];
    int errors;
    int results;
    int clears;

    function new();
      longint base_m[Bands] = '{3013, 8490, 15374, 29328, 47918,
                                130408, 226555, 344937, 366438, 379009};
      longint beta_m[Bands] = '{-993973, -983019, -969252, -941343, -904163,
                                -739184, -546889, -310127, -267123, -241981};
      longint gamma_m[Bands] = '{1993901, 1982437, 1967331, 1934254, 1884869,
                                 1582718, 1015267, -181410, -521151, -808451};
      longint db_n[37] = '{125892541, 141253754, 158489319, 177827941, 199526231,
                           223872114, 251188643, 281838293, 316227766, 354813389,
                           398107171, 446683592, 501187234, 562341325, 630957344,
                           707945784, 794328235, 891250938, 1000000000, 1122018454,
                           1258925412, 1412537545, 1584893192, 1778279410, 1995262315,
                           64'sd2238721139, 64'sd2511886432, 64'sd2818382931,
                           64'sd3162277660, 64'sd3548133892, 64'sd3981071706,
                           64'sd4466835922, 64'sd5011872336, 64'sd5623413252,
                           64'sd6309573445, 64'sd7079457844, 64'sd7943282347};
      for (int k = 0; k < Bands; k++) begin
        base_q29[k]  = to_q29(base_m[k]);
        beta_q29[k]  = to_q29(beta_m[k]);
        gamma_q29[k] = to_q29(gamma_m[k]);
      end
      for (int i = 0; i < 37; i++) gain_q27[i] = (db_n[i] * 134217728 + 500000000) / 1000000000;
      gains_lo = '0;
      gains_hi = '0;
      preamp = '0;
      errors = 0;
      results = 0;
      clears = 0;
      wipe();
    endfunction

    function longint to_q29(longint m);
      return (m * 536870912 + (m < 0 ? -500000 : 500000)) / 1000000;
    endfunction

    function void wipe();
      foreach (x_hist[c, i]) x_hist[c][i] = 0;
      foreach (y_hist[c, i]) y_hist[c][i] = 0;
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint db_to_lin(logic [5:0] code);
      int g;
      g = int'(signed'(code));
      if (g < -18) g = -18;
      if (g > 18) g = 18;
      return gain_q27[g + 18];
    endfunction

    function void set_reg(logic [1:0] idx, logic [29:0] val);
      case (idx)
        CfgGainsLow:  gains_lo = val;
        CfgGainsHigh: gains_hi = val;
        CfgPreamp:    preamp = val[5:0];
        default: ;
      endcase
    endfunction

    function void note_word(logic cmd, logic [31:0] smp, logic ch);
      longint alpha[Bands];
      longint pre27, pre25, x1, x3, diff, acc, gm1, a0, t, y;
      logic [29:0] r;
      if (cmd == CmdClear) begin
        wipe();
        clears++;
        return;
      end
      pre27 = db_to_lin(preamp);
      pre25 = pre27 >>> 2;
      for (int k = 0; k < Bands; k++) begin
        r = (k < 5) ? gains_lo : gains_hi;
        gm1 = db_to_lin(r[(k % 5) * 6 +: 6]) - (64'sd1 <<< 27);
        a0 = (base_q29[k] * gm1) >>> 29;
        alpha[k] = (a0 * pre27) >>> 29;
      end
      x1 = x_hist[ch][0];
      x3 = x_hist[ch][2];
      diff = (x1 - x3) >>> 1;
      acc = (pre25 * x1) >>> 25;
      for (int k = 0; k < Bands; k += 2) begin
        if (alpha[k] != 0 || alpha[k+1] != 0) begin
          for (int b = k; b < k + 2; b++) begin
            t = ((alpha[b] * diff) >>> 25) + ((gamma_q29[b] * y_hist[ch][2*b]) >>> 29)
              + ((beta_q29[b] * y_hist[ch][2*b+1]) >>> 29);
            y = clip32(t);
            y_hist[ch][2*b+1] = y_hist[ch][2*b];
            y_hist[ch][2*b] = y;
            acc += y;
          end
        end
      end
      x_hist[ch][2] = x_hist[ch][1];
      x_hist[ch][1] = x_hist[ch][0];
      x_hist[ch][0] = longint'(signed'(smp));
      pending.push_back({ch, 32'(clip32(acc))});
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [39:0] data);
      logic [32:0] want;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h", data));
        return;
      end
      want = pending.pop_front();
      if (data[31:0] !== want[31:0])
        report($sformatf("sample_out %h, want %h", data[31:0], want[31:0]));
      if (data[32] !== want[32])
        report($sformatf("channel_out %b, want %b", data[32], want[32]));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [29:0] cfg_data_i = '0;

  eq_scoreboard sb = new();
  bit  calm = 1'b0;
  int  cycles = 0;
  int  settings = 0;

  ten_band_graphic_equalizer_core #(.CHANNEL_COUNT(ChanCount)) uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);

  task automatic write_reg(logic [1:0] idx, logic [29:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic send_word(logic cmd, logic [31:0] smp, logic ch);
    bit taken;
    while (!calm && $urandom_range(99) < 27) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {7'b0, ch, smp};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_axis_tready;
      @(negedge clk_i);
    end
    sb.note_word(cmd, smp, ch);
  endtask

  function automatic logic [29:0] gain_word(int mode);
    logic [29:0] w;
    for (int f = 0; f < 5; f++) begin
      case (mode)
        1: w[f*6 +: 6] = 6'sd18;
        2: w[f*6 +: 6] = -6'sd18;
        3: w[f*6 +: 6] = f[0] ? 6'sd31 : -6'sd32;
        4: w[f*6 +: 6] = ($urandom_range(1) != 0) ? 6'($urandom) : 6'd0;
        default: w[f*6 +: 6] = 6'($urandom);
      endcase
    end
    return w;
  endfunction

  task automatic configure(int mode, int pre);
    write_reg(CfgGainsLow, gain_word(mode));
    write_reg(CfgGainsHigh, gain_word(mode));
    write_reg(CfgPreamp, 30'(6'(pre)));
    settings++;
  endtask

  initial begin
    logic [31:0] smp;
    int          pre;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero gains: every band pair held
    send_word(CmdSample, 32'h7FFFFFFF, 1'b0);
    send_word(CmdSample, 32'h80000000, 1'b1);
    send_word(CmdSample, 32'h00000000, 1'b0);
    send_word(CmdSample, 32'h12345678, 1'b1);
    drain();
    configure(1, 20);
    send_word(CmdSample, 32'h7FFFFFFF, 1'b0);
    send_word(CmdSample, 32'h80000000, 1'b0);
    send_word(CmdSample, 32'h7FFFFFFF, 1'b0);
    send_word(CmdSample, 32'h80000000, 1'b1);
    send_word(CmdSample, 32'h7FFFFFFF, 1'b1);
    send_word(CmdSample, 32'h00000001, 1'b0);
    send_word(CmdClear, 32'hFFFFFFFF, 1'b1);
    send_word(CmdSample, 32'h40000000, 1'b0);
    send_word(CmdSample, 32'hC0000000, 1'b0);
    drain();
    configure(2, -20);
    send_word(CmdSample, 32'h7FFFFFFF, 1'b1);
    send_word(CmdSample, 32'h80000000, 1'b1);
    send_word(CmdSample, 32'h00000000, 1'b1);
    send_word(CmdClear, 32'h00000000, 1'b0);
    send_word(CmdSample, 32'hFFFFFFFF, 1'b0);
    drain();
    configure(3, 0);
    send_word(CmdSample, 32'h7FFFFFFF, 1'b0);
    send_word(CmdSample, 32'h80000000, 1'b0);
    send_word(CmdSample, 32'h55555555, 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      pre = (ph == 1) ? 20 : (ph == 2) ? -20 : $urandom_range(40) - 20;
      configure(ph % 5, pre);
      calm = (ph == 5);
      for (int n = 0; n < 150; n++) begin
        if (ph == 3 && n == 75) drain();
        smp = $urandom;
        if ($urandom_range(99) < 40) smp = 32'(signed'(smp) >>> $urandom_range(8, 2));
        send_word(($urandom_range(99) < 3) ? CmdClear : CmdSample, smp, 1'($urandom));
      end
      calm = 1'b0;
      drain();
    end

    $display("covered %0d results, %0d clears, %0d gain settings", sb.results, sb.clears,
             settings);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ ten_band_graphic_equalizer_core.f @@
sv/tbge_pkg.sv
sv/tbge_front.sv
sv/tbge_back.sv
sv/ten_band_graphic_equalizer_core.sv
tb/tb_ten_band_graphic_equalizer_core.sv
